@@ rtl/pvar_pkg.sv @@
// Shared types, constants and helper functions for the pairwise view angle range core.
package pvar_pkg;

	localparam int MAX_VIEWS_DEF = 16;
	localparam int RAY_W = 48;
	localparam int CORDIC_STEPS = 24;
	localparam logic [14:0] PI_Q13 = 15'd25736;
	localparam logic signed [32:0] PI_Q24 = 33'sd52707179;
	localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

	typedef enum logic [3:0] {
		S_IDLE, S_NORM, S_CHECK, S_RD_I, S_LD_I, S_RD_J, S_ANG, S_WAIT, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQ, N_SQST, N_SQRT, N_DIV, N_OUT
	} norm_state_t;

	typedef enum logic [2:0] {
		A_IDLE, A_DOT, A_CLAMP, A_SQ, A_SQST, A_SQRT, A_CORD, A_FIN
	} ang_state_t;

	function automatic logic signed [31:0] atan_q24(input logic [4:0] idx);
		logic signed [31:0] r;
		case (idx)
			5'd0: r = 32'sd13176795;
			5'd1: r = 32'sd7778716;
			5'd2: r = 32'sd4110060;
			5'd3: r = 32'sd2086331;
			5'd4: r = 32'sd1047214;
			5'd5: r = 32'sd524117;
			5'd6: r = 32'sd262123;
			5'd7: r = 32'sd131069;
			5'd8: r = 32'sd65536;
			5'd9: r = 32'sd32768;
			5'd10: r = 32'sd16384;
			5'd11: r = 32'sd8192;
			5'd12: r = 32'sd4096;
			5'd13: r = 32'sd2048;
			5'd14: r = 32'sd1024;
			5'd15: r = 32'sd512;
			5'd16: r = 32'sd256;
			5'd17: r = 32'sd128;
			5'd18: r = 32'sd64;
			5'd19: r = 32'sd32;
			5'd20: r = 32'sd16;
			5'd21: r = 32'sd8;
			5'd22: r = 32'sd4;
			5'd23: r = 32'sd2;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// Arithmetic right shift that truncates toward zero.
	function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
			input logic [4:0] s);
		logic signed [33:0] a;
		if (v[33]) begin
			a = -v;
			return -(a >>> s);
		end
		return v >>> s;
	endfunction

endpackage

@@ rtl/pvar_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pvar_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/pvar_isqrt.sv @@
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module pvar_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] v,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] b_q;
	logic [63:0] rb;

	assign rb = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v;
			r_q <= '0;
			b_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];
endmodule

@@ rtl/pvar_norm.sv @@
// Ray normalizer: scales a difference vector to a Q1.14 unit vector.
module pvar_norm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [32:0]         dx,
	input  logic signed [32:0]         dy,
	input  logic signed [32:0]         dz,
	output logic                       done,
	output logic [pvar_pkg::RAY_W-1:0] ray
);
	import pvar_pkg::*;

	norm_state_t st_q, st_d;
	logic [32:0] mag_q [3];
	logic        neg_q [3];
	logic [32:0] m;
	logic [1:0]  k_q;
	logic [59:0] prod_q;
	logic [61:0] sum_q;
	logic [47:0] rem_q [3];
	logic [47:0] dv_q;
	logic [14:0] quo_q [3];
	logic [3:0]  bit_q;
	logic        sq_start;
	logic        sq_done;
	logic [31:0] sq_root;
	logic signed [32:0] din [3];

	assign din[0] = dx;
	assign din[1] = dy;
	assign din[2] = dz;

	pvar_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .v({2'b00, sum_q}),
		.done(sq_done), .root(sq_root)
	);

	always_comb begin
		m = mag_q[0];
		if (mag_q[1] > m) begin
			m = mag_q[1];
		end
		if (mag_q[2] > m) begin
			m = mag_q[2];
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			N_IDLE: if (start) st_d = N_SHIFT;
			N_SHIFT: begin
				if (m == '0) begin
					st_d = N_OUT;
				end else if (m < 33'd1 << 30 && m >= 33'd1 << 29) begin
					st_d = N_SQ;
				end
			end
			N_SQ: if (k_q == 2'd3) st_d = N_SQST;
			N_SQST: st_d = N_SQRT;
			N_SQRT: if (sq_done) st_d = N_DIV;
			N_DIV: if (bit_q == 4'd0) st_d = N_OUT;
			N_OUT: st_d = N_IDLE;
			default: st_d = N_IDLE;
		endcase
	end

	always_comb begin
		sq_start = (st_q == N_SQST);
		done = (st_q == N_OUT);
		for (int k = 0; k < 3; k++) begin
			ray[16*k +: 16] = neg_q[k] ? -{1'b0, quo_q[k]} : {1'b0, quo_q[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= din[k][32];
					mag_q[k] <= din[k][32] ? -din[k] : din[k];
				end
			end
			N_SHIFT: begin
				k_q <= '0;
				sum_q <= '0;
				for (int k = 0; k < 3; k++) begin
					quo_q[k] <= '0;
					if (m >= 33'd1 << 30) begin
						mag_q[k] <= mag_q[k] >> 1;
					end else if (m < 33'd1 << 29) begin
						mag_q[k] <= mag_q[k] << 1;
					end
				end
			end
			N_SQ: begin
				k_q <= k_q + 2'd1;
				if (k_q != 2'd3) begin
					prod_q <= mag_q[k_q][29:0] * mag_q[k_q][29:0];
				end
				if (k_q != 2'd0) begin
					sum_q <= sum_q + {2'b00, prod_q};
				end
			end
			N_SQRT: begin
				bit_q <= 4'd14;
				dv_q <= {1'b0, sq_root, 15'd0};
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= {3'd0, mag_q[k][29:0], 15'd0} + {16'd0, sq_root};
				end
			end
			N_DIV: begin
				bit_q <= bit_q - 4'd1;
				dv_q <= dv_q >> 1;
				for (int k = 0; k < 3; k++) begin
					if (rem_q[k] >= dv_q) begin
						rem_q[k] <= rem_q[k] - dv_q;
						quo_q[k][bit_q] <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule

@@ rtl/pvar_angle.sv @@
// Angle unit: dot product of two unit rays, clamp, arccos by square root and CORDIC.
module pvar_angle (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pvar_pkg::RAY_W-1:0] ray_a,
	input  logic [pvar_pkg::RAY_W-1:0] ray_b,
	output logic                       done,
	output logic [14:0]                angle
);
	import pvar_pkg::*;

	ang_state_t st_q, st_d;
	logic [RAY_W-1:0]   a_q, b_q;
	logic [1:0]         k_q;
	logic signed [31:0] prod_q;
	logic signed [33:0] dot_q;
	logic               neg_q;
	logic [28:0]        ad_q;
	logic [57:0]        sq_q;
	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [4:0]         i_q;
	logic signed [33:0] xs, ys;
	logic               sq_start, sq_done;
	logic [31:0]        sq_root;
	logic signed [33:0] dc;
	logic signed [32:0] tot;
	logic signed [32:0] rnd;

	pvar_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.v((64'd1 << 56) - {6'd0, sq_q}), .done(sq_done), .root(sq_root)
	);

	assign xs = shr_tz(x_q, i_q);
	assign ys = shr_tz(y_q, i_q);

	always_comb begin
		dc = dot_q;
		if (dot_q > ONE_Q28) begin
			dc = ONE_Q28;
		end else if (dot_q < -ONE_Q28) begin
			dc = -ONE_Q28;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			A_IDLE: if (start) st_d = A_DOT;
			A_DOT: if (k_q == 2'd3) st_d = A_CLAMP;
			A_CLAMP: st_d = A_SQ;
			A_SQ: st_d = A_SQST;
			A_SQST: st_d = A_SQRT;
			A_SQRT: if (sq_done) st_d = A_CORD;
			A_CORD: if (i_q == 5'(CORDIC_STEPS - 1)) st_d = A_FIN;
			A_FIN: st_d = A_IDLE;
			default: st_d = A_IDLE;
		endcase
	end

	always_comb begin
		sq_start = (st_q == A_SQST);
		done = (st_q == A_FIN);
		tot = neg_q ? PI_Q24 - 33'(z_q) : 33'(z_q);
		if (tot < 0) begin
			tot = '0;
		end
		rnd = (tot + 33'sd1024) >>> 11;
		angle = (rnd > 33'(PI_Q13)) ? PI_Q13 : rnd[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			A_IDLE: begin
				a_q <= ray_a;
				b_q <= ray_b;
				k_q <= '0;
				dot_q <= '0;
			end
			A_DOT: begin
				k_q <= k_q + 2'd1;
				if (k_q != 2'd3) begin
					prod_q <= $signed(a_q[16*k_q +: 16]) * $signed(b_q[16*k_q +: 16]);
				end
				if (k_q != 2'd0) begin
					dot_q <= dot_q + 34'(prod_q);
				end
			end
			A_CLAMP: begin
				neg_q <= dc[33];
				ad_q <= dc[33] ? 29'(-dc) : dc[28:0];
			end
			A_SQ: sq_q <= ad_q * ad_q;
			A_SQRT: begin
				x_q <= {5'd0, ad_q};
				y_q <= {2'b00, sq_root};
				z_q <= '0;
				i_q <= '0;
			end
			A_CORD: begin
				i_q <= i_q + 5'd1;
				if (!y_q[33]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_q24(i_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_q24(i_q);
				end
			end
			default: begin
			end
		endcase
	end
endmodule

@@ rtl/pairwise_view_angle_range_core.sv @@
// Each item takes one transfer, after which the core stalls while its ray is normalized:
// a one-bit-per-cycle alignment shift, three squarings, a square root and a divider that
// forms the 15-bit quotients. A center equal to the point skips all of that. The core then
// passes through its check state before the next item can be taken. An item flagged
// last_view then walks every stored pair of rays through the angle unit (a three-term dot
// product, a squaring, a square root and 24 CORDIC steps per pair). Rays live in a RAM of
// MAX_VIEWS entries; views past MAX_VIEWS are dropped.
// The result sits in an output register, so the next set may start while it waits.
module pairwise_view_angle_range_core #(
	parameter int MAX_VIEWS = pvar_pkg::MAX_VIEWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic               last_view,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [14:0]        min_angle,
	output logic [14:0]        max_angle
);
	import pvar_pkg::*;

	localparam int CW = $clog2(MAX_VIEWS + 1);
	localparam int IW = $clog2(MAX_VIEWS);

	state_t st_q, st_d;
	logic [CW-1:0]    cnt_q, i_q, j_q;
	logic             last_q;
	logic [RAY_W-1:0] ray_i_q;
	logic [14:0]      mn_q, mx_q;
	logic             out_valid_q;
	logic [14:0]      min_angle_q, max_angle_q;
	logic             accept, room, load;
	logic             norm_start, norm_done;
	logic [RAY_W-1:0] norm_ray;
	logic             ram_we;
	logic [IW-1:0]    raddr;
	logic [RAY_W-1:0] rdata;
	logic             ang_start, ang_done;
	logic [14:0]      ang;

	assign accept = in_valid && !in_stall;
	assign room = (cnt_q < CW'(MAX_VIEWS));

	pvar_norm u_norm (
		.clk(clk), .arst_n(arst_n), .start(norm_start),
		.dx(33'(center_x) - 33'(point_x)),
		.dy(33'(center_y) - 33'(point_y)),
		.dz(33'(center_z) - 33'(point_z)),
		.done(norm_done), .ray(norm_ray)
	);

	pvar_ram #(.WIDTH(RAY_W), .DEPTH(MAX_VIEWS)) u_rays (
		.clk(clk), .we(ram_we), .waddr(cnt_q[IW-1:0]), .wdata(norm_ray),
		.raddr(raddr), .rdata(rdata)
	);

	pvar_angle u_angle (
		.clk(clk), .arst_n(arst_n), .start(ang_start), .ray_a(ray_i_q),
		.ray_b(rdata), .done(ang_done), .angle(ang)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (accept) st_d = room ? S_NORM : S_CHECK;
			S_NORM: if (norm_done) st_d = S_CHECK;
			S_CHECK: begin
				if (!last_q) begin
					st_d = S_IDLE;
				end else if (cnt_q < CW'(2)) begin
					st_d = S_DONE;
				end else begin
					st_d = S_RD_I;
				end
			end
			S_RD_I: st_d = S_LD_I;
			S_LD_I: st_d = S_ANG;
			S_RD_J: st_d = S_ANG;
			S_ANG: st_d = S_WAIT;
			S_WAIT: begin
				if (ang_done) begin
					if ({1'b0, j_q} + 1'b1 < {1'b0, cnt_q}) begin
						st_d = S_RD_J;
					end else if ({1'b0, i_q} + 2'd2 < {1'b0, cnt_q}) begin
						st_d = S_RD_I;
					end else begin
						st_d = S_DONE;
					end
				end
			end
			S_DONE: if (load) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (st_q != S_IDLE);
		norm_start = (st_q == S_IDLE) && accept && room;
		ram_we = (st_q == S_NORM) && norm_done;
		raddr = (st_q == S_RD_I) ? i_q[IW-1:0] : j_q[IW-1:0];
		ang_start = (st_q == S_ANG);
		load = (st_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ram_we) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (load) begin
				cnt_q <= '0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= last_view;
		end
		case (st_q)
			S_CHECK: begin
				i_q <= '0;
				j_q <= CW'(1);
				mn_q <= PI_Q13;
				mx_q <= '0;
			end
			S_LD_I: ray_i_q <= rdata;
			S_WAIT: begin
				if (ang_done) begin
					if (ang < mn_q) begin
						mn_q <= ang;
					end
					if (ang > mx_q) begin
						mx_q <= ang;
					end
					if (j_q + 1'b1 < cnt_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + CW'(2);
					end
				end
			end
			default: begin
			end
		endcase
		if (load) begin
			min_angle_q <= mn_q;
			max_angle_q <= mx_q;
		end
	end

	assign out_valid = out_valid_q;
	assign min_angle = min_angle_q;
	assign max_angle = max_angle_q;
endmodule

@@ rtl/pvar_checker.sv @@
// Port-level assertions for the pairwise view angle range core, with the bind that attaches them.
module pvar_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [14:0] min_angle,
	input logic [14:0] max_angle
);
	import pvar_pkg::*;

	// A held result keeps its value until the transfer completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_angle) && $stable(max_angle))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_angle <= PI_Q13 && max_angle <= PI_Q13)
		else $error("angle above pi");

	// Either a real spread or the empty-set answer of pi and zero.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_angle <= max_angle) || (min_angle == PI_Q13 && max_angle == '0))
		else $error("min above max");

	// Every accepted item keeps the block busy for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");
endmodule

bind pairwise_view_angle_range_core pvar_checker u_pvar_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .min_angle(min_angle),
	.max_angle(max_angle)
);

@@ bench/pairwise_view_angle_range_core_tb.sv @@
// Self-checking testbench for the pairwise view angle range core.
module pairwise_view_angle_range_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pvar_pkg::*;

	localparam int VIEW_CAP = MAX_VIEWS_DEF;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int HOLD_CYCLES = 4000;
	localparam int ITEM_TARGET = 1850;

	typedef struct packed {
		logic [14:0] min_a;
		logic [14:0] max_a;
	} angle_range_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] point_x, point_y, point_z;
	logic signed [31:0] center_x, center_y, center_z;
	logic last_view;
	logic out_valid;
	logic out_stall;
	logic [14:0] min_angle, max_angle;

	pairwise_view_angle_range_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.last_view(last_view),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_angle(min_angle), .max_angle(max_angle)
	);

	angle_range_t expected_ranges[$];
	logic [47:0] ray_store[VIEW_CAP];
	int stored_views;
	int err_cnt;
	int items_sent;
	longint cycle_cnt;
	bit calm;
	bit hold_req;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [47:0] unit_ray(longint dx, longint dy, longint dz);
		longint d[3];
		longint unsigned mag[3], m, sum, len, q;
		logic [47:0] r;
		d[0] = dx;
		d[1] = dy;
		d[2] = dz;
		m = 0;
		sum = 0;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = d[k] < 0 ? longint'(-d[k]) : longint'(d[k]);
			if (mag[k] > m)
				m = mag[k];
		end
		if (m == 0)
			return r;
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int k = 0; k < 3; k++)
				mag[k] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int k = 0; k < 3; k++)
				mag[k] <<= 1;
		end
		for (int k = 0; k < 3; k++)
			sum += mag[k] * mag[k];
		len = floor_sqrt(sum);
		for (int k = 0; k < 3; k++) begin
			q = ((mag[k] << 15) + len) / (2 * len);
			r[16*k +: 16] = d[k] < 0 ? 16'(-longint'(q)) : 16'(q);
		end
		return r;
	endfunction

	function automatic longint trunc_shift(longint v, int s);
		if (v >= 0)
			return longint'(longint'(unsigned'(v)) >> s);
		return -longint'(longint'(unsigned'(-v)) >> s);
	endfunction

	function automatic logic [14:0] dot_to_angle(longint dot);
		longint ad, x, y, z, xs, ys, total, one;
		longint tbl[24];
		tbl = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		one = 64'sd1 << 28;
		if (dot > one)
			dot = one;
		if (dot < -one)
			dot = -one;
		ad = dot < 0 ? -dot : dot;
		x = ad;
		y = longint'(floor_sqrt((64'd1 << 56) - ad * ad));
		z = 0;
		for (int i = 0; i < 24; i++) begin
			xs = trunc_shift(x, i);
			ys = trunc_shift(y, i);
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += tbl[i];
			end else begin
				x -= ys;
				y += xs;
				z -= tbl[i];
			end
		end
		total = dot < 0 ? longint'(PI_Q24) - z : z;
		if (total < 0)
			total = 0;
		total = (total + 1024) >>> 11;
		if (total > longint'(PI_Q13))
			total = longint'(PI_Q13);
		return total[14:0];
	endfunction

	// Mirrors the block for one accepted view and queues the range when a set closes.
	task automatic predict_view();
		angle_range_t res;
		longint dot;
		logic signed [15:0] a, b;
		logic [14:0] ang;
		if (stored_views < VIEW_CAP) begin
			ray_store[stored_views] = unit_ray(longint'(center_x) - longint'(point_x),
				longint'(center_y) - longint'(point_y),
				longint'(center_z) - longint'(point_z));
			stored_views++;
		end
		if (last_view) begin
			res.min_a = PI_Q13;
			res.max_a = '0;
			for (int i = 0; i < stored_views; i++)
				for (int j = i + 1; j < stored_views; j++) begin
					dot = 0;
					for (int k = 0; k < 3; k++) begin
						a = ray_store[i][16*k +: 16];
						b = ray_store[j][16*k +: 16];
						dot += longint'(a) * longint'(b);
					end
					ang = dot_to_angle(dot);
					if (ang < res.min_a)
						res.min_a = ang;
					if (ang > res.max_a)
						res.max_a = ang;
				end
			stored_views = 0;
			expected_ranges.push_back(res);
		end
	endtask

	// Called at a rising edge; leaves at the rising edge of the transfer.
	task automatic send_view(input logic signed [31:0] px, py, pz, cx, cy, cz,
			input logic lv);
		bit st;
		while (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		center_x <= cx;
		center_y <= cy;
		center_z <= cz;
		last_view <= lv;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
		predict_view();
		items_sent++;
	endtask

	function automatic logic signed [31:0] rand_coord(bit wide);
		if (wide)
			return $urandom;
		return $signed($urandom_range(2000)) - 1000;
	endfunction

	task automatic send_set(input int n, input bit wide);
		logic signed [31:0] px, py, pz;
		px = rand_coord(wide);
		py = rand_coord(wide);
		pz = rand_coord(wide);
		for (int i = 0; i < n; i++)
			send_view(px, py, pz, rand_coord(wide), rand_coord(wide), rand_coord(wide),
				i == n - 1);
	endtask

	task automatic test_extremes();
		send_view(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_view(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
		send_view(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
		send_view(0, 0, 0, 1, 0, 0, 1'b0);
		send_view(0, 0, 0, -1, 0, 0, 1'b1);
		send_view(0, 0, 0, 32'sh00010000, 0, 0, 1'b0);
		send_view(0, 0, 0, 0, 32'sh00010000, 0, 1'b0);
		send_view(0, 0, 0, 0, 0, 32'sh00010000, 1'b1);
	endtask

	task automatic test_special_cases();
		// A lone view and an empty pair set both give pi and zero.
		send_view(5, 6, 7, 100, 200, 300, 1'b1);
		// A center on the point becomes a zero ray at right angles to everything.
		send_view(42, 42, 42, 42, 42, 42, 1'b0);
		send_view(42, 42, 42, 1000, 42, 42, 1'b1);
		send_view(3, 3, 3, 900, 900, 900, 1'b0);
		send_view(3, 3, 3, 1800, 1800, 1800, 1'b1);
		// Views past the capacity are dropped, yet the last one still closes the set.
		for (int i = 0; i < VIEW_CAP + 3; i++)
			send_view(0, 0, 0, rand_coord(1), rand_coord(1), rand_coord(1),
				i == VIEW_CAP + 2);
	endtask

	task automatic test_random_sets();
		int n, pick;
		while (items_sent < ITEM_TARGET - 60) begin
			pick = $urandom_range(99);
			if (pick < 10)
				n = 1;
			else if (pick < 96)
				n = $urandom_range(5, 2);
			else
				n = $urandom_range(VIEW_CAP + 4, 8);
			send_set(n, $urandom_range(1));
		end
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int s = 0; s < 6; s++)
			send_set(2, 1);
	endtask

	task automatic test_no_idle();
		calm = 1'b1;
		while (items_sent < ITEM_TARGET)
			send_set($urandom_range(4, 2), $urandom_range(1));
		calm = 1'b0;
	endtask

	// Receiver side: random stalls, plus a long hold when asked.
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 38);
		end
	end

	// Outputs only change at rising edges, so the falling edge sees the next transfer.
	always @(negedge clk) begin
		angle_range_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ranges.size() == 0) begin
				$error("unexpected result min_angle=%0d max_angle=%0d", min_angle, max_angle);
				err_cnt++;
			end else begin
				exp_r = expected_ranges.pop_front();
				if (min_angle !== exp_r.min_a) begin
					$error("min_angle expected %0d actual %0d", exp_r.min_a, min_angle);
					err_cnt++;
				end
				if (max_angle !== exp_r.max_a) begin
					$error("max_angle expected %0d actual %0d", exp_r.max_a, max_angle);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		out_stall = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		center_x = '0;
		center_y = '0;
		center_z = '0;
		last_view = 1'b0;
		arst_n = 1'b0;
		err_cnt = 0;
		items_sent = 0;
		stored_views = 0;
		cycle_cnt = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_special_cases();
		test_backpressure();
		test_random_sets();
		test_no_idle();
		in_valid <= 1'b0;
		while (expected_ranges.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ pairwise_view_angle_range_core.f @@
rtl/pvar_pkg.sv
rtl/pvar_ram.sv
rtl/pvar_isqrt.sv
rtl/pvar_norm.sv
rtl/pvar_angle.sv
rtl/pairwise_view_angle_range_core.sv
rtl/pvar_checker.sv
bench/pairwise_view_angle_range_core_tb.sv
